// File: sv/prqt_pkg.sv
// Shared command codes and controller/datapath interface types for the ready-queue table.
package prqt_pkg;

   localparam int CMD_W = 3;

   localparam logic [CMD_W-1:0] CMD_ADD_READY     = 3'd0;
   localparam logic [CMD_W-1:0] CMD_ADD_TIMEOUT   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE_TASK   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_EMPTY_PRIO    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_EMPTY_TIMEOUT = 3'd4;
   localparam logic [CMD_W-1:0] CMD_QUERY         = 3'd5;

   localparam int TASK_ID_W  = 4;
   localparam int PRIO_REQ_W = 3;
   localparam int NEXT_PRI_W = 4;

   // Controller to datapath commands.
   typedef struct packed {
      logic latch_req;   // capture the request fields
      logic head_rd;     // start a list walk at the selected head
      logic walk_step;   // follow the link just read and read the next one
      logic rem_rd;      // read both links of the task node
      logic app_w1;      // link the tail to the task node
      logic app_w2;      // terminate the list at the task node
      logic rem_wr;      // splice the task node out of its list
      logic clr_wr;      // point the selected head back to itself
      logic resp_load;   // register the result item
   } ctrl_cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic             task_ok;
      logic             pri_ok;
      logic             walk_found;
      logic             walk_abort;
   } dp_stat_type;

endpackage

// File: sv/prqt_ctrl.sv
// Sequencing state machine for the ready-queue table.
module prqt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  prqt_pkg::dp_stat_type stat,
   output prqt_pkg::ctrl_cmd_type cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_WALK   = 3'd2;
   localparam logic [2:0] S_APP_W1 = 3'd3;
   localparam logic [2:0] S_APP_W2 = 3'd4;
   localparam logic [2:0] S_REM_WR = 3'd5;
   localparam logic [2:0] S_RESP   = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.latch_req = 1'b1;
               state_in      = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_RESP;
            unique case (stat.command)
               prqt_pkg::CMD_ADD_READY: begin
                  if (stat.task_ok && stat.pri_ok) begin
                     cmd.head_rd = 1'b1;
                     state_in    = S_WALK;
                  end
               end
               prqt_pkg::CMD_ADD_TIMEOUT: begin
                  if (stat.task_ok) begin
                     cmd.head_rd = 1'b1;
                     state_in    = S_WALK;
                  end
               end
               prqt_pkg::CMD_REMOVE_TASK: begin
                  if (stat.task_ok) begin
                     cmd.rem_rd = 1'b1;
                     state_in   = S_REM_WR;
                  end
               end
               prqt_pkg::CMD_EMPTY_PRIO: begin
                  cmd.clr_wr = stat.pri_ok;
               end
               prqt_pkg::CMD_EMPTY_TIMEOUT: begin
                  cmd.clr_wr = 1'b1;
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end
         S_WALK: begin
            if (stat.walk_found) begin
               state_in = S_APP_W1;
            end else if (stat.walk_abort) begin
               state_in = S_RESP;
            end else begin
               cmd.walk_step = 1'b1;
            end
         end
         S_APP_W1: begin
            cmd.app_w1 = 1'b1;
            state_in   = S_APP_W2;
         end
         S_APP_W2: begin
            cmd.app_w2 = 1'b1;
            state_in   = S_RESP;
         end
         S_REM_WR: begin
            cmd.rem_wr = 1'b1;
            state_in   = S_RESP;
         end
         S_RESP: begin
            cmd.resp_load = 1'b1;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// File: sv/prqt_dp.sv
// Link memories, walk registers, head status flags and result registers.
module prqt_dp #(
   parameter int NUM_TASKS = 16,
   parameter int NUM_PRIO  = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [prqt_pkg::CMD_W-1:0]          req_command,
   input  logic [prqt_pkg::TASK_ID_W-1:0]      req_task_id,
   input  logic [prqt_pkg::PRIO_REQ_W-1:0]     req_priority_req,
   input  prqt_pkg::ctrl_cmd_type              cmd,
   output prqt_pkg::dp_stat_type               stat,
   output logic                                rsp_valid,
   output logic [prqt_pkg::NEXT_PRI_W-1:0]     rsp_next_priority,
   output logic                                rsp_timeout_empty
);

   localparam int NODE_COUNT = NUM_PRIO + 1 + NUM_TASKS;
   localparam int NW = $clog2(NODE_COUNT);
   localparam int SW = $clog2(NODE_COUNT + 1);
   localparam int HW = $clog2(NUM_PRIO + 1);
   localparam int HD = 1 << HW;

   function automatic logic [NW-1:0] safe_node(input logic [NW-1:0] n);
      safe_node = (32'(n) < 32'(NODE_COUNT)) ? n : '0;
   endfunction

   // Request capture.
   logic [prqt_pkg::CMD_W-1:0]      cmd_ff;
   logic [prqt_pkg::TASK_ID_W-1:0]  tid_ff;
   logic [prqt_pkg::PRIO_REQ_W-1:0] pri_ff;

   // Walk registers.
   logic [NW-1:0] cur_ff, cur_in;
   logic [SW-1:0] steps_ff, steps_in;

   // Link memories and their registered read ports.
   logic [NW-1:0] next_mem_ff [NODE_COUNT];
   logic [NW-1:0] prev_mem_ff [NODE_COUNT];
   logic [NW-1:0] next_raw_ff, prev_raw_ff;
   logic [NW-1:0] next_ra_ff, prev_ra_ff;
   logic          next_sub_ff, prev_sub_ff;
   logic [NW-1:0] next_raddr, prev_raddr;
   logic [NW-1:0] next_rd, prev_rd;

   // Write ports.
   logic          next_we, prev_we;
   logic [NW-1:0] next_waddr, next_wdata, prev_waddr, prev_wdata;

   // Head entries: written-since-reset marks and non-empty flags.
   logic [HD-1:0] next_hv_ff, next_hv_in;
   logic [HD-1:0] prev_hv_ff, prev_hv_in;
   logic [HD-1:0] flag_ff, flag_in;

   logic [NW-1:0] head_sel, task_node, nx, pv;
   logic [HW-1:0] enc;
   logic          rsp_valid_ff;
   logic [prqt_pkg::NEXT_PRI_W-1:0] rsp_pri_ff;
   logic          rsp_te_ff;

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         cmd_ff <= req_command;
         tid_ff <= req_task_id;
         pri_ff <= req_priority_req;
      end
   end

   assign task_node = NW'(32'(NUM_PRIO) + 32'd1 + 32'(tid_ff));
   assign head_sel  = (cmd_ff == prqt_pkg::CMD_ADD_TIMEOUT ||
                       cmd_ff == prqt_pkg::CMD_EMPTY_TIMEOUT) ?
                      NW'(NUM_PRIO) : NW'(pri_ff);

   // A head that was never written still holds its reset value: itself.
   assign next_rd = next_sub_ff ? next_ra_ff : next_raw_ff;
   assign prev_rd = prev_sub_ff ? prev_ra_ff : prev_raw_ff;
   assign nx      = safe_node(next_rd);
   assign pv      = safe_node(prev_rd);

   always_comb begin
      next_raddr = cur_ff;
      prev_raddr = task_node;
      if (cmd.head_rd) begin
         next_raddr = head_sel;
      end else if (cmd.walk_step) begin
         next_raddr = nx;
      end else if (cmd.rem_rd) begin
         next_raddr = task_node;
      end
   end

   always_comb begin
      cur_in   = cur_ff;
      steps_in = steps_ff;
      if (cmd.head_rd) begin
         cur_in   = head_sel;
         steps_in = '0;
      end else if (cmd.walk_step) begin
         cur_in   = nx;
         steps_in = steps_ff + SW'(1);
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      steps_ff <= steps_in;
   end

   always_comb begin
      next_we    = 1'b0;
      next_waddr = cur_ff;
      next_wdata = task_node;
      prev_we    = 1'b0;
      prev_waddr = task_node;
      prev_wdata = cur_ff;
      if (cmd.app_w1) begin
         next_we = 1'b1;
         prev_we = 1'b1;
      end else if (cmd.app_w2) begin
         next_we    = 1'b1;
         next_waddr = task_node;
      end else if (cmd.rem_wr) begin
         next_we    = 1'b1;
         next_waddr = pv;
         next_wdata = (nx == task_node) ? pv : nx;
         prev_we    = 1'b1;
         prev_waddr = nx;
         prev_wdata = pv;
      end else if (cmd.clr_wr) begin
         next_we    = 1'b1;
         next_waddr = head_sel;
         next_wdata = head_sel;
         prev_we    = 1'b1;
         prev_waddr = head_sel;
         prev_wdata = head_sel;
      end
   end

   always_ff @(posedge clock) begin
      if (next_we) begin
         next_mem_ff[next_waddr] <= next_wdata;
      end
      next_raw_ff <= next_mem_ff[next_raddr];
      next_ra_ff  <= next_raddr;
      next_sub_ff <= (32'(next_raddr) <= 32'(NUM_PRIO)) && !next_hv_ff[next_raddr[HW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (prev_we) begin
         prev_mem_ff[prev_waddr] <= prev_wdata;
      end
      prev_raw_ff <= prev_mem_ff[prev_raddr];
      prev_ra_ff  <= prev_raddr;
      prev_sub_ff <= (32'(prev_raddr) <= 32'(NUM_PRIO)) && !prev_hv_ff[prev_raddr[HW-1:0]];
   end

   always_comb begin
      next_hv_in = next_hv_ff;
      prev_hv_in = prev_hv_ff;
      flag_in    = flag_ff;
      if (next_we && (32'(next_waddr) <= 32'(NUM_PRIO))) begin
         next_hv_in[next_waddr[HW-1:0]] = 1'b1;
         flag_in[next_waddr[HW-1:0]]    = (next_wdata != next_waddr);
      end
      if (prev_we && (32'(prev_waddr) <= 32'(NUM_PRIO))) begin
         prev_hv_in[prev_waddr[HW-1:0]] = 1'b1;
      end
   end

   always_comb begin
      enc = HW'(NUM_PRIO);
      for (int p = NUM_PRIO - 1; p >= 1; p--) begin
         if (flag_ff[p]) begin
            enc = HW'(p);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_hv_ff   <= '0;
         prev_hv_ff   <= '0;
         flag_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         next_hv_ff   <= next_hv_in;
         prev_hv_ff   <= prev_hv_in;
         flag_ff      <= flag_in;
         rsp_valid_ff <= cmd.resp_load;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.resp_load) begin
         rsp_pri_ff <= prqt_pkg::NEXT_PRI_W'(enc);
         rsp_te_ff  <= !flag_ff[NUM_PRIO];
      end
   end

   assign stat.command    = cmd_ff;
   assign stat.task_ok    = (32'(tid_ff) < 32'(NUM_TASKS));
   assign stat.pri_ok     = (32'(pri_ff) < 32'(NUM_PRIO));
   assign stat.walk_found = (next_rd == cur_ff);
   assign stat.walk_abort = (32'(steps_ff) >= 32'(NODE_COUNT));

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_next_priority = rsp_pri_ff;
   assign rsp_timeout_empty = rsp_te_ff;

endmodule

// File: sv/priority_ready_queue_table_top.sv
// Top level of the priority ready-queue table: controller plus link datapath.
// Query, empty and out-of-range items pass through DECODE and RESP, a remove through DECODE,
// REM_WR and RESP, and an append through DECODE, WALK (reading one link after another), APP_W1,
// APP_W2 and RESP when it finds its tail, or DECODE, WALK and RESP when dropped as a runaway walk.
// One item at a time: busy falls in the result cycle, so a new item is taken only after the last;
// results cannot be stalled. Reset idles the controller and clears the head flags and strobe.
module priority_ready_queue_table_top #(
   parameter int NUM_TASKS = 16,
   parameter int NUM_PRIO  = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [prqt_pkg::CMD_W-1:0]          req_command,
   input  logic [prqt_pkg::TASK_ID_W-1:0]      req_task_id,
   input  logic [prqt_pkg::PRIO_REQ_W-1:0]     req_priority_req,
   output logic                                rsp_valid,
   output logic [prqt_pkg::NEXT_PRI_W-1:0]     rsp_next_priority,
   output logic                                rsp_timeout_empty
);

   // The controller decodes the item and walks the sequence of link reads and writes.
   // The datapath owns both link memories; every priority head, the timeout head and
   // every task is one node, each with a next and a previous link. Head nodes carry a
   // written mark so an untouched head reads back as pointing to itself, and a
   // non-empty flag that lets the result be formed without reading the memories.
   prqt_pkg::ctrl_cmd_type cmd;
   prqt_pkg::dp_stat_type  stat;

   prqt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   prqt_dp #(
      .NUM_TASKS (NUM_TASKS),
      .NUM_PRIO  (NUM_PRIO)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_command       (req_command),
      .req_task_id       (req_task_id),
      .req_priority_req  (req_priority_req),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_valid         (rsp_valid),
      .rsp_next_priority (rsp_next_priority),
      .rsp_timeout_empty (rsp_timeout_empty)
   );

endmodule

// File: sv/prqt_chk.sv
// Port-level checker for the ready-queue table and its bind to the top level.
module prqt_chk (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input logic [prqt_pkg::CMD_W-1:0]      req_command,
   input logic                            rsp_valid,
   input logic                            rsp_timeout_empty
);

   // Reset leaves the block idle with no result pending.
   a_reset_idle: assert property (@(posedge clock) reset |=> (!busy && !rsp_valid))
      else $error("block not idle after reset");

   // An accepted item keeps the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not make the block busy");

   // Every finished item produces its result as busy drops.
   a_done_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("item finished without a result");

   // A result is only produced by an item that was in progress.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without an item in progress");

   // Emptying the timeout queue reports it as empty in its own result.
   a_empty_timeout: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_command == prqt_pkg::CMD_EMPTY_TIMEOUT)
      |-> ##3 (rsp_valid && rsp_timeout_empty))
      else $error("timeout queue not empty after emptying it");

endmodule

bind priority_ready_queue_table_top prqt_chk u_prqt_chk (.*);
